// ----- rtl/core/afr_pkg.sv -----
// Package for the API frame receiver: phase and status codes, field widths.
// Used by the channel interfaces and by api_frame_receiver; depends on nothing.

package afr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [BYTE_W-1:0] SUM_GOOD          = 8'hFF;
  localparam logic [BYTE_W-1:0] DELIM_RESET       = 8'h7E;
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RESET  = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_DELIMITER = 2'd0,
    REG_MAX_LENGTH      = 2'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_DATA   = 3'd3,
    PH_CHECK  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_OK      = 2'd1,
    ST_LEN_ERR = 2'd2,
    ST_SUM_ERR = 2'd3
  } status_t;

endpackage

// ----- rtl/core/afr_rx_if.sv -----
// Input channel of the API frame receiver: one received serial byte per word.
// Depends on afr_pkg.

interface afr_rx_if;
  import afr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/core/afr_tx_if.sv -----
// Result channel of the API frame receiver: payload byte, index and frame status.
// Depends on afr_pkg.

interface afr_tx_if;
  import afr_pkg::*;

  logic              valid;
  logic              ready;
  logic              payload_valid;
  logic [BYTE_W-1:0] payload_byte;
  logic [LEN_W-1:0]  payload_index;
  logic [1:0]        frame_status;

  modport source (output valid, output payload_valid, output payload_byte,
                  output payload_index, output frame_status, input ready);
  modport sink   (input valid, input payload_valid, input payload_byte,
                  input payload_index, input frame_status, output ready);
endinterface

// ----- rtl/core/afr_cfg_if.sv -----
// Configuration write channel of the API frame receiver: register index and data.
// Depends on afr_pkg.

interface afr_cfg_if;
  import afr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/api_frame_receiver.sv -----
// API frame receiver: hunts for a start delimiter, takes a big-endian length,
// streams payload bytes with their index and checks the 8-bit frame checksum.
// Depends on afr_pkg, afr_rx_if, afr_tx_if and afr_cfg_if.
// Each accepted byte's result word is registered for the next cycle; the receiver takes
// one byte per cycle, and input stalls only while a result word waits unread.
// Reset is synchronous: hunting phase, empty result register, default registers.

module api_frame_receiver (
  input logic       clk,
  input logic       rst,
  afr_rx_if.sink    rx,
  afr_tx_if.source  tx,
  afr_cfg_if.sink   cfg
);
  import afr_pkg::*;

  logic [BYTE_W-1:0] start_delimiter;
  logic [LEN_W-1:0]  max_length;

  phase_t            phase;
  phase_t            phase_next;
  logic [LEN_W-1:0]  frame_length;
  logic [LEN_W-1:0]  frame_length_next;
  logic [LEN_W-1:0]  byte_index;
  logic [LEN_W-1:0]  byte_index_next;
  logic [BYTE_W-1:0] running_sum;
  logic [BYTE_W-1:0] running_sum_next;

  logic              res_pvalid;
  logic [BYTE_W-1:0] res_pbyte;
  logic [LEN_W-1:0]  res_pidx;
  status_t           res_status;

  logic              out_valid;
  logic              out_pvalid;
  logic [BYTE_W-1:0] out_pbyte;
  logic [LEN_W-1:0]  out_pidx;
  status_t           out_status;

  logic              accept;
  logic [BYTE_W-1:0] sum_add;
  logic [LEN_W-1:0]  index_inc;
  logic [LEN_W-1:0]  length_full;

  assign rx.ready  = !out_valid || tx.ready;
  assign accept    = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_delimiter <= DELIM_RESET;
      max_length      <= MAX_LENGTH_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_START_DELIMITER: start_delimiter <= cfg.data[BYTE_W-1:0];
        REG_MAX_LENGTH:      max_length      <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign sum_add     = running_sum + rx.rx_byte;
  assign index_inc   = byte_index + 1'b1;
  assign length_full = {frame_length[LEN_W-1:BYTE_W], rx.rx_byte};

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    byte_index_next   = byte_index;
    running_sum_next  = running_sum;
    res_pvalid        = 1'b0;
    res_pbyte         = '0;
    res_pidx          = '0;
    res_status        = ST_NONE;
    unique case (phase)
      PH_LEN_HI: begin
        frame_length_next = {rx.rx_byte, {BYTE_W{1'b0}}};
        phase_next        = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_length_next = length_full;
        running_sum_next  = '0;
        byte_index_next   = '0;
        if (length_full > max_length) begin
          res_status = ST_LEN_ERR;
          phase_next = PH_HUNT;
        end else if (length_full == '0) begin
          phase_next = PH_CHECK;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        res_pvalid       = 1'b1;
        res_pbyte        = rx.rx_byte;
        res_pidx         = byte_index;
        running_sum_next = sum_add;
        byte_index_next  = index_inc;
        if (index_inc >= frame_length || index_inc == '0) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        running_sum_next = sum_add;
        res_status       = (sum_add == SUM_GOOD) ? ST_OK : ST_SUM_ERR;
        phase_next       = PH_HUNT;
      end
      default: begin
        phase_next = (rx.rx_byte == start_delimiter) ? PH_LEN_HI : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      frame_length <= '0;
      byte_index   <= '0;
      running_sum  <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      byte_index   <= byte_index_next;
      running_sum  <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pvalid <= res_pvalid;
      out_pbyte  <= res_pbyte;
      out_pidx   <= res_pidx;
      out_status <= res_status;
    end
  end

  assign tx.valid         = out_valid;
  assign tx.payload_valid = out_pvalid;
  assign tx.payload_byte  = out_pbyte;
  assign tx.payload_index = out_pidx;
  assign tx.frame_status  = out_status;

  a_payload_no_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_pvalid |-> out_status == ST_NONE)
    else $error("Payload word carries a frame status.");

  a_data_length_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> frame_length != '0 && byte_index < frame_length)
    else $error("Payload phase with index outside the frame length.");

  a_hunt_stays: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_HUNT && rx.rx_byte != start_delimiter |=> phase == PH_HUNT)
    else $error("Left hunting without a start delimiter.");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx.ready |-> !accept)
    else $error("Input accepted while a result word is held.");

endmodule

// ----- verif/afr_tb_pkg.sv -----
// Scoreboard for the API frame receiver testbench: a byte-level frame parser
// that predicts every result word, and the queue of words still to arrive.
// Depends on afr_pkg.
`timescale 1ns / 1ps

package afr_tb_pkg;
  import afr_pkg::*;

  typedef struct packed {
    logic              pay_valid;
    logic [BYTE_W-1:0] pay_byte;
    logic [LEN_W-1:0]  pay_index;
    status_t           status;
  } rx_word_t;

  class frame_rx_scoreboard;
    phase_t            phase;
    logic [LEN_W-1:0]  frame_len;
    logic [LEN_W-1:0]  byte_idx;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] delim;
    logic [LEN_W-1:0]  max_len;
    rx_word_t          expected_words[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       n_payload;
    int unsigned       n_ok;
    int unsigned       n_len_err;
    int unsigned       n_sum_err;

    function new();
      phase = PH_HUNT;
      frame_len = '0;
      byte_idx = '0;
      sum = '0;
      delim = DELIM_RESET;
      max_len = MAX_LENGTH_RESET;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
      case (index)
        REG_START_DELIMITER: delim = data[BYTE_W-1:0];
        REG_MAX_LENGTH:      max_len = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      rx_word_t w;
      w = '{1'b0, '0, '0, ST_NONE};
      case (phase)
        PH_LEN_HI: begin
          frame_len = {b, 8'h00};
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_len = {frame_len[LEN_W-1:BYTE_W], b};
          sum = '0;
          byte_idx = '0;
          if (frame_len > max_len) begin
            w.status = ST_LEN_ERR;
            phase = PH_HUNT;
          end else if (frame_len == '0) begin
            phase = PH_CHECK;
          end else begin
            phase = PH_DATA;
          end
        end
        PH_DATA: begin
          w.pay_valid = 1'b1;
          w.pay_byte = b;
          w.pay_index = byte_idx;
          sum = sum + b;
          byte_idx = byte_idx + 1'b1;
          if (byte_idx >= frame_len || byte_idx == '0) phase = PH_CHECK;
        end
        PH_CHECK: begin
          sum = sum + b;
          w.status = (sum == SUM_GOOD) ? ST_OK : ST_SUM_ERR;
          phase = PH_HUNT;
        end
        default: begin
          phase = (b == delim) ? PH_LEN_HI : PH_HUNT;
        end
      endcase
      expected_words.push_back(w);
    endfunction

    function void flag(string field, int unsigned want, int unsigned got);
      errors++;
      $display("[%0t] %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_word(rx_word_t got);
      rx_word_t exp;
      if (expected_words.size() == 0) begin
        errors++;
        $display("[%0t] unexpected word: expected none, actual %0h", $time, got);
        return;
      end
      exp = expected_words.pop_front();
      checked++;
      if (got.pay_valid !== exp.pay_valid) flag("payload_valid", exp.pay_valid, got.pay_valid);
      if (got.pay_byte !== exp.pay_byte) flag("payload_byte", exp.pay_byte, got.pay_byte);
      if (got.pay_index !== exp.pay_index) flag("payload_index", exp.pay_index, got.pay_index);
      if (got.status !== exp.status) flag("frame_status", exp.status, got.status);
      if (exp.pay_valid) n_payload++;
      case (exp.status)
        ST_OK:      n_ok++;
        ST_LEN_ERR: n_len_err++;
        ST_SUM_ERR: n_sum_err++;
        default: ;
      endcase
    endfunction
  endclass

endpackage

// ----- verif/api_frame_receiver_tb.sv -----
// Top-level testbench for api_frame_receiver: directed and random serial byte
// streams with random stalls on both sides, checked word by word by the scoreboard.
// Depends on afr_pkg, the channel interfaces and afr_tb_pkg.
`timescale 1ns / 1ps

module api_frame_receiver_tb;
  import afr_pkg::*;
  import afr_tb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  afr_rx_if  rx();
  afr_tx_if  tx();
  afr_cfg_if cfg();

  api_frame_receiver dut (
    .clk(clk),
    .rst(rst),
    .rx(rx),
    .tx(tx),
    .cfg(cfg)
  );

  frame_rx_scoreboard sb;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned idle_cycles;
  int unsigned bytes_sent;
  int unsigned cfg_writes;
  logic [BYTE_W-1:0] body_q[$];

  always #10 clk = ~clk;

  always @(negedge clk) begin
    tx.ready <= (snk_idle_pct == 0) || ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (cfg.valid && cfg.ready) sb.write_reg(cfg.index, cfg.data);
      if (rx.valid && rx.ready) sb.note_byte(rx.rx_byte);
      if (tx.valid && tx.ready) begin
        sb.check_word(rx_word_t'{tx.payload_valid, tx.payload_byte, tx.payload_index,
                                 status_t'(tx.frame_status)});
      end
      if ((cfg.valid && cfg.ready) || (rx.valid && rx.ready) || (tx.valid && tx.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $time, idle_cycles);
        $display("api_frame_receiver_tb: errors");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      rx.valid <= 1'b0;
      @(negedge clk);
    end
    rx.valid <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    while (sb.expected_words.size() != 0) @(negedge clk);
  endtask

  // Register writes go out back to back with valid held high between them.
  task automatic apply_setting(input logic [BYTE_W-1:0] delim, input logic [LEN_W-1:0] max_len,
                               input bit spare);
    logic [CFG_IDX_W-1:0] idx_q[$];
    logic [CFG_DAT_W-1:0] dat_q[$];
    idx_q.push_back(REG_START_DELIMITER);
    dat_q.push_back({8'($urandom_range(0, 255)), delim});
    idx_q.push_back(REG_MAX_LENGTH);
    dat_q.push_back(max_len);
    if (spare) begin
      idx_q.push_back(REG_SPARE_2);
      dat_q.push_back(16'($urandom_range(0, 65535)));
      idx_q.push_back(REG_SPARE_3);
      dat_q.push_back(16'($urandom_range(0, 65535)));
    end
    rx.valid <= 1'b0;
    wait_drained();
    foreach (idx_q[i]) begin
      cfg.valid <= 1'b1;
      cfg.index <= idx_q[i];
      cfg.data <= dat_q[i];
      do @(posedge clk); while (!cfg.ready);
      @(negedge clk);
      cfg_writes++;
    end
    cfg.valid <= 1'b0;
  endtask

  // Sends delimiter, length and, unless the length is refused, body_q and a checksum.
  task automatic send_frame(input logic [BYTE_W-1:0] delim, input logic [LEN_W-1:0] len,
                            input bit good_sum);
    logic [BYTE_W-1:0] acc;
    acc = '0;
    send_byte(delim);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    if (len > sb.max_len) return;
    foreach (body_q[i]) begin
      send_byte(body_q[i]);
      acc = acc + body_q[i];
    end
    send_byte(good_sum ? ~acc : ~acc ^ 8'($urandom_range(1, 255)));
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned pick;
    int unsigned top;
    int unsigned over;
    pick = $urandom_range(0, 99);
    if (sb.max_len != 16'hFFFF && pick < 12) begin
      over = (pick < 4) ? 32'hFFFF : sb.max_len + $urandom_range(1, 3);
      return (over > 32'hFFFF) ? 16'hFFFF : 16'(over);
    end
    if (pick < 20 && sb.max_len <= 16'd64) return sb.max_len;
    top = (pick < 28) ? 60 : 12;
    if (top > sb.max_len) top = sb.max_len;
    return 16'($urandom_range(0, top));
  endfunction

  task automatic random_traffic(input int unsigned budget);
    int unsigned used;
    int unsigned pick;
    int unsigned cut;
    logic [LEN_W-1:0] len;
    logic [BYTE_W-1:0] noise;
    used = 0;
    while (used < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        noise = 8'($urandom_range(0, 255));
        send_byte((noise == sb.delim) ? ~noise : noise);
      end else if (pick < 14) begin
        // A frame cut off inside its payload; the next frame is partly eaten.
        len = 16'($urandom_range(1, 8));
        send_byte(sb.delim);
        send_byte(8'h00);
        send_byte(len[7:0]);
        cut = $urandom_range(0, len - 1);
        repeat (cut) send_byte(8'($urandom_range(0, 255)));
        used += 3 + cut;
      end else begin
        len = pick_length();
        body_q.delete();
        if (len <= sb.max_len) repeat (len) body_q.push_back(8'($urandom_range(0, 255)));
        send_frame(sb.delim, len, $urandom_range(0, 99) < 85);
        used += 3 + body_q.size();
      end
    end
  endtask

  task automatic directed_frames();
    send_byte(8'h00);
    send_byte(8'hFF);
    body_q = '{8'h00, 8'hFF, DELIM_RESET};
    send_frame(DELIM_RESET, 16'd3, 1'b1);
    body_q.delete();
    send_frame(DELIM_RESET, 16'd0, 1'b1);
    send_frame(DELIM_RESET, 16'd0, 1'b0);
    send_frame(DELIM_RESET, MAX_LENGTH_RESET + 16'd1, 1'b1);
    send_frame(DELIM_RESET, 16'hFFFF, 1'b1);
    body_q = '{8'h5A};
    send_frame(DELIM_RESET, 16'd1, 1'b0);
  endtask

  initial begin
    logic [BYTE_W-1:0] delim;
    logic [LEN_W-1:0]  max_len;
    bit mid_frame;
    sb = new();
    rx.valid = 1'b0;
    rx.rx_byte = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    src_idle_pct = 22;
    snk_idle_pct = 65;
    bytes_sent = 0;
    cfg_writes = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_frames();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        src_idle_pct = 65;
        snk_idle_pct = 22;
      end else if (p == 4) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      case (p)
        0: begin delim = 8'h00; max_len = 16'd0; end
        1: begin delim = 8'hFF; max_len = 16'hFFFF; end
        2: begin delim = DELIM_RESET; max_len = 16'd5; end
        3: begin delim = 8'($urandom_range(0, 255)); max_len = 16'd1; end
        4: begin delim = 8'hA5; max_len = 16'd12; end
        default: begin delim = 8'($urandom_range(0, 255)); max_len = 16'd300; end
      endcase
      // Half the time the registers change after a delimiter and a length high byte are sent.
      mid_frame = $urandom_range(0, 1);
      if (mid_frame) begin
        send_byte(sb.delim);
        send_byte(8'h00);
      end
      apply_setting(delim, max_len, p == 2 || p == 4);
      if (mid_frame) send_byte(8'($urandom_range(0, 20)));
      random_traffic(125);
    end

    rx.valid <= 1'b0;
    wait_drained();
    repeat (4) @(negedge clk);

    $display("Sent %0d bytes and %0d register writes over six register settings.",
             bytes_sent, cfg_writes);
    $display("Checked %0d words: %0d payload, %0d good, %0d length and %0d checksum errors.",
             sb.checked, sb.n_payload, sb.n_ok, sb.n_len_err, sb.n_sum_err);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("api_frame_receiver_tb: clean");
    end else begin
      $display("api_frame_receiver_tb: errors");
    end
    $finish;
  end

endmodule
